// File: rtl/biquad_cascade_df1_filter_defines.svh
// ----------------------------------------------------------------------------
// Biquad cascade assertion macros
// Shared assertion helpers that check implication properties on clk.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_DF1_FILTER_DEFINES_SVH
`define BIQUAD_CASCADE_DF1_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad cascade assertion failed");

// Next-cycle implication, disabled during reset.
`define BCDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad cascade assertion failed");

`endif

// File: rtl/bcdf_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade package
// Widths, codes, sequencer states and coefficient helpers.
// ----------------------------------------------------------------------------
package bcdf_pkg;

    localparam int MAX_STAGES_DEF = 8;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 32;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int ACC_W          = 51;
    localparam int QUOT_W         = 17;
    localparam int SLOTS          = 6;
    localparam int HIST_PER       = 4;

    localparam logic [1:0] MODE_FILTER = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A0 = 3'd3;
    localparam logic [2:0] SLOT_A1 = 3'd4;
    localparam logic [2:0] SLOT_A2 = 3'd5;

    localparam logic [1:0] HIST_U1 = 2'd0;
    localparam logic [1:0] HIST_U2 = 2'd1;
    localparam logic [1:0] HIST_Y1 = 2'd2;
    localparam logic [1:0] HIST_Y2 = 2'd3;

    localparam logic [2:0] TERM_LAST = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;
    localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_NEG = 16'sh8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM_RD,
        ST_TERM_MUL,
        ST_TERM_ACC,
        ST_A0_RD,
        ST_A0_WAIT,
        ST_DIV,
        ST_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              done;
        logic              big;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

    function automatic logic signed [COEF_W-1:0] coef_reset_value(input logic [2:0] slot);
        case (slot)
            SLOT_B0, SLOT_A0: return COEF_ONE;
            default:          return '0;
        endcase
    endfunction

    function automatic logic [2:0] term_slot(input logic [2:0] term);
        case (term)
            3'd0:    return SLOT_B0;
            3'd1:    return SLOT_B1;
            3'd2:    return SLOT_B2;
            3'd3:    return SLOT_A1;
            default: return SLOT_A2;
        endcase
    endfunction

    function automatic logic [1:0] term_hist(input logic [2:0] term);
        case (term)
            3'd1:    return HIST_U1;
            3'd2:    return HIST_U2;
            3'd3:    return HIST_Y1;
            default: return HIST_Y2;
        endcase
    endfunction

endpackage

// File: rtl/bcdf_div.sv
// ----------------------------------------------------------------------------
// Biquad cascade serial divider
// Restoring divider producing a 17-bit quotient, one bit per cycle, with a
// flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module bcdf_div #(
    parameter int NUM_W = bcdf_pkg::ACC_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NUM_W-1:0]          num_mag,
    input  logic [bcdf_pkg::COEF_W-1:0] den_mag,
    output bcdf_pkg::div_res_t        res
);
    import bcdf_pkg::*;

    localparam int HI_W  = NUM_W - QUOT_W;
    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [COEF_W-1:0] rem_reg;
    logic [COEF_W-1:0] den_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              big_reg;

    logic [HI_W-1:0]   num_hi;
    logic [COEF_W:0]   trial;
    logic [COEF_W:0]   diff;
    logic              fits;

    assign num_hi = num_mag[NUM_W-1:QUOT_W];
    assign trial  = {rem_reg, low_reg[QUOT_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign fits   = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_hi[COEF_W-1:0];
            low_reg  <= num_mag[QUOT_W-1:0];
            den_reg  <= den_mag;
            quot_reg <= '0;
            big_reg  <= num_hi >= HI_W'(den_mag);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign res = '{done: done_reg, big: big_reg, quot: quot_reg};

endmodule

// File: rtl/biquad_cascade_df1_filter.sv
// ----------------------------------------------------------------------------
// Biquad cascade, direct form I
// A filter request runs its Q1.15 sample through sections 0 to stage_count-1
// (0 counts as 1, counts above MAX_STAGES as MAX_STAGES) on one shared
// 32x16 multiplier and a serial divider. Each section runs five
// multiply-accumulate terms (read, multiply, accumulate), the a0 read, the
// 17-bit serial divide unless its a0 is zero, and four history writes through
// the single history write port. Coefficient and clear requests are taken
// without leaving idle. The input is not ready while a sample is in work.
// ----------------------------------------------------------------------------
`include "biquad_cascade_df1_filter_defines.svh"

module biquad_cascade_df1_filter #(
    parameter int MAX_STAGES = bcdf_pkg::MAX_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_in[15:0], coef_stage[18:16], coef_slot[21:19], coef_value[53:22]
    input  logic [55:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_out[15:0]
    output logic [15:0] m_axis_tdata,
    // overflow[0]
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import bcdf_pkg::*;

    localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CDEP  = SLOTS * MAX_STAGES;
    localparam int CA_W  = $clog2(CDEP);
    localparam int HDEP  = HIST_PER * MAX_STAGES;
    localparam int HA_W  = SW + 2;

    state_t state_reg, state_next;

    logic [3:0]    stage_count_reg;
    logic [SW-1:0] stage_reg;
    logic [SW-1:0] last_idx;
    logic [2:0]    term_reg;
    logic [1:0]    wb_reg;

    logic signed [SAMPLE_W-1:0] cur_u_reg, u1_reg, y1_reg, y_reg;
    logic                       ovf_reg;
    logic                       neg_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_ovf_reg;

    logic signed [COEF_W-1:0]   coef_mem [CDEP];
    logic [CDEP-1:0]            coef_vld_reg;
    logic signed [COEF_W-1:0]   coef_rd_reg;
    logic                       coef_rd_vld_reg;
    logic [2:0]                 coef_rd_slot_reg;

    logic signed [SAMPLE_W-1:0] hist_mem [HDEP];
    logic [HDEP-1:0]            hist_vld_reg;
    logic signed [SAMPLE_W-1:0] hist_rd_reg;
    logic                       hist_rd_vld_reg;

    logic [CA_W-1:0]            coef_rd_addr;
    logic [2:0]                 coef_rd_slot;
    logic [HA_W-1:0]            hist_rd_addr;
    logic                       hist_we;
    logic [HA_W-1:0]            hist_wa;
    logic signed [SAMPLE_W-1:0] hist_wd;
    logic                       div_start;
    logic                       out_load;

    logic                       in_accept;
    logic [1:0]                 in_mode;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [2:0]                 in_stage;
    logic [2:0]                 in_slot;
    logic signed [COEF_W-1:0]   in_value;
    logic                       coef_we;
    logic [CA_W-1:0]            coef_wa;

    logic signed [COEF_W-1:0]   coef_val;
    logic signed [SAMPLE_W-1:0] hist_val;
    logic signed [SAMPLE_W-1:0] op_val;
    logic [ACC_W-1:0]           num_mag;
    logic [COEF_W-1:0]          den_mag;
    div_res_t                   div_res;

    assign in_mode   = s_axis_tuser;
    assign in_sample = s_axis_tdata[15:0];
    assign in_stage  = s_axis_tdata[18:16];
    assign in_slot   = s_axis_tdata[21:19];
    assign in_value  = s_axis_tdata[53:22];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ovf_reg;

    assign coef_we = in_accept && (in_mode == MODE_COEF) && (32'(in_stage) < MAX_STAGES)
                     && (32'(in_slot) < SLOTS);
    assign coef_wa = CA_W'(int'(in_stage) * SLOTS + int'(in_slot));

    assign coef_val = coef_rd_vld_reg ? coef_rd_reg : coef_reset_value(coef_rd_slot_reg);
    assign hist_val = hist_rd_vld_reg ? hist_rd_reg : '0;
    assign op_val   = (term_reg == 3'd0) ? cur_u_reg : hist_val;
    assign num_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign den_mag  = coef_val[COEF_W-1] ? COEF_W'(-coef_val) : COEF_W'(coef_val);

    always_comb
    begin
        if (stage_count_reg == 4'd0)
            last_idx = '0;
        else if (32'(stage_count_reg) > MAX_STAGES)
            last_idx = SW'(MAX_STAGES - 1);
        else
            last_idx = SW'(stage_count_reg - 4'd1);
    end

    bcdf_div #(
        .NUM_W (ACC_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .res     (div_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        coef_rd_slot = term_slot(term_reg);
        coef_rd_addr = CA_W'(int'(stage_reg) * SLOTS + int'(coef_rd_slot));
        hist_rd_addr = {stage_reg, term_hist(term_reg)};
        hist_we      = 1'b0;
        hist_wa      = {stage_reg, HIST_U2};
        hist_wd      = u1_reg;
        div_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_mode == MODE_FILTER)
                    state_next = ST_TERM_RD;
            end
            ST_TERM_RD:
                state_next = ST_TERM_MUL;
            ST_TERM_MUL:
                state_next = ST_TERM_ACC;
            ST_TERM_ACC:
                state_next = (term_reg == TERM_LAST) ? ST_A0_RD : ST_TERM_RD;
            ST_A0_RD:
            begin
                coef_rd_slot = SLOT_A0;
                coef_rd_addr = CA_W'(int'(stage_reg) * SLOTS + int'(SLOT_A0));
                state_next   = ST_A0_WAIT;
            end
            ST_A0_WAIT:
            begin
                if (coef_val == '0)
                    state_next = ST_WB;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                hist_we = 1'b1;
                case (wb_reg)
                    2'd0:
                    begin
                        hist_wa = {stage_reg, HIST_U2};
                        hist_wd = u1_reg;
                    end
                    2'd1:
                    begin
                        hist_wa = {stage_reg, HIST_U1};
                        hist_wd = cur_u_reg;
                    end
                    2'd2:
                    begin
                        hist_wa = {stage_reg, HIST_Y2};
                        hist_wd = y1_reg;
                    end
                    default:
                    begin
                        hist_wa = {stage_reg, HIST_Y1};
                        hist_wd = y_reg;
                    end
                endcase
                if (wb_reg == 2'd3)
                    state_next = (stage_reg >= last_idx) ? ST_DONE : ST_TERM_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= 4'd1;
            stage_reg       <= '0;
            term_reg        <= '0;
            wb_reg          <= '0;
            out_valid_reg   <= 1'b0;
            coef_vld_reg    <= '0;
            hist_vld_reg    <= '0;
            coef_rd_vld_reg <= 1'b0;
            hist_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                stage_count_reg <= cfg_data;
            if (state_reg == ST_IDLE)
            begin
                stage_reg <= '0;
                term_reg  <= '0;
            end
            if (state_reg == ST_TERM_ACC)
                term_reg <= term_reg + 3'd1;
            if (state_reg == ST_WB)
            begin
                wb_reg <= wb_reg + 2'd1;
                if (wb_reg == 2'd3)
                begin
                    stage_reg <= stage_reg + 1'b1;
                    term_reg  <= '0;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (coef_we)
                coef_vld_reg[coef_wa] <= 1'b1;
            if (in_accept && in_mode == MODE_CLEAR)
                hist_vld_reg <= '0;
            else if (hist_we)
                hist_vld_reg[hist_wa] <= 1'b1;
            coef_rd_vld_reg <= coef_vld_reg[coef_rd_addr];
            hist_rd_vld_reg <= hist_vld_reg[hist_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_wa] <= in_value;
        coef_rd_reg      <= coef_mem[coef_rd_addr];
        coef_rd_slot_reg <= coef_rd_slot;
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        hist_rd_reg <= hist_mem[hist_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_u_reg <= in_sample;
                ovf_reg   <= 1'b0;
                acc_reg   <= '0;
            end
            ST_TERM_MUL:
            begin
                prod_reg <= coef_val * op_val;
                if (term_reg == 3'd1)
                    u1_reg <= hist_val;
                if (term_reg == 3'd3)
                    y1_reg <= hist_val;
            end
            ST_TERM_ACC:
            begin
                if (term_reg <= 3'd2)
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                else
                    acc_reg <= acc_reg - ACC_W'(prod_reg);
            end
            ST_A0_WAIT:
            begin
                neg_reg <= acc_reg[ACC_W-1] ^ coef_val[COEF_W-1];
                if (coef_val == '0)
                begin
                    ovf_reg <= 1'b1;
                    if (acc_reg > 0)
                        y_reg <= SAT_POS;
                    else if (acc_reg < 0)
                        y_reg <= SAT_NEG;
                    else
                        y_reg <= '0;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (neg_reg)
                    begin
                        if (div_res.big || div_res.quot > 17'd32768)
                        begin
                            y_reg   <= SAT_NEG;
                            ovf_reg <= 1'b1;
                        end
                        else
                            y_reg <= SAMPLE_W'(-div_res.quot);
                    end
                    else
                    begin
                        if (div_res.big || div_res.quot > 17'd32767)
                        begin
                            y_reg   <= SAT_POS;
                            ovf_reg <= 1'b1;
                        end
                        else
                            y_reg <= SAMPLE_W'(div_res.quot);
                    end
                end
            end
            ST_WB:
            begin
                if (wb_reg == 2'd3)
                begin
                    cur_u_reg <= y_reg;
                    acc_reg   <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= y_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    `BCDF_ASSERT_IMP(a_div_done_in_div, div_res.done, state_reg == ST_DIV)
    `BCDF_ASSERT_IMP(a_term_in_range, state_reg == ST_TERM_RD, term_reg <= TERM_LAST)
    `BCDF_ASSERT_NXT(a_filter_starts, in_accept && in_mode == MODE_FILTER, state_reg == ST_TERM_RD)
    `BCDF_ASSERT_NXT(a_result_posted, out_load, m_axis_tvalid && state_reg == ST_IDLE)

endmodule

// File: verif/biquad_cascade_df1_filter_checker.sv
// ----------------------------------------------------------------------------
// Biquad cascade checker
// Watches the request, result and configuration channels, keeps its own
// copy of the section coefficients and histories, predicts each filtered
// sample and compares it with what the block returns.
// ----------------------------------------------------------------------------
module biquad_cascade_df1_filter_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          overflow_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import bcdf_pkg::*;

    localparam int SECTIONS = MAX_STAGES_DEF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               ovf;
    } filt_result_t;

    logic signed [31:0] coef_mem [SECTIONS][SLOTS];
    logic signed [15:0] u_hist   [SECTIONS][2];
    logic signed [15:0] y_hist   [SECTIONS][2];
    logic [3:0]         sections_cfg;
    filt_result_t       expected_q[$];

    function automatic filt_result_t run_cascade(input logic signed [15:0] x);
        filt_result_t       r;
        int                 n;
        longint             acc;
        longint             a0;
        longint unsigned    mag_n;
        longint unsigned    mag_d;
        longint unsigned    quo;
        logic signed [15:0] v;
        logic signed [15:0] y;
        n = (sections_cfg == 0) ? 1 : ((sections_cfg > SECTIONS) ? SECTIONS : sections_cfg);
        v = x;
        r.ovf = 1'b0;
        for (int s = 0; s < n; s++) begin
            acc = longint'(coef_mem[s][SLOT_B0]) * longint'(v)
                + longint'(coef_mem[s][SLOT_B1]) * longint'(u_hist[s][0])
                + longint'(coef_mem[s][SLOT_B2]) * longint'(u_hist[s][1])
                - longint'(coef_mem[s][SLOT_A1]) * longint'(y_hist[s][0])
                - longint'(coef_mem[s][SLOT_A2]) * longint'(y_hist[s][1]);
            a0 = longint'(coef_mem[s][SLOT_A0]);
            if (a0 == 0) begin
                r.ovf = 1'b1;
                y = (acc > 0) ? SAT_POS : ((acc < 0) ? SAT_NEG : 16'sd0);
            end
            else begin
                mag_n = (acc < 0) ? longint'(-acc) : acc;
                mag_d = (a0 < 0) ? longint'(-a0) : a0;
                quo = mag_n / mag_d;
                if ((acc < 0) != (a0 < 0)) begin
                    if (quo > 32768) begin
                        r.ovf = 1'b1;
                        y = SAT_NEG;
                    end
                    else begin
                        y = 16'(-longint'(quo));
                    end
                end
                else if (quo > 32767) begin
                    r.ovf = 1'b1;
                    y = SAT_POS;
                end
                else begin
                    y = 16'(quo);
                end
            end
            u_hist[s][1] = u_hist[s][0];
            u_hist[s][0] = v;
            y_hist[s][1] = y_hist[s][0];
            y_hist[s][0] = y;
            v = y;
        end
        r.sample = v;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t got;
        filt_result_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SECTIONS; s++)
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    coef_mem[s][k] = (k == SLOT_B0 || k == SLOT_A0) ? COEF_ONE : '0;
                end
                u_hist[s] = '{default: '0};
                y_hist[s] = '{default: '0};
            end
            sections_cfg = 4'd1;
            expected_q.delete();
            fail_count = 0;
            outstanding = 0;
            overflow_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sections_cfg = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    MODE_FILTER:
                    begin
                        expected_q.push_back(run_cascade(s_axis_tdata[15:0]));
                    end
                    MODE_COEF:
                    begin
                        if (s_axis_tdata[21:19] < SLOTS)
                        begin
                            coef_mem[s_axis_tdata[18:16]][s_axis_tdata[21:19]] =
                                s_axis_tdata[53:22];
                        end
                    end
                    MODE_CLEAR:
                    begin
                        for (int s = 0; s < SECTIONS; s++)
                        begin
                            u_hist[s] = '{default: '0};
                            y_hist[s] = '{default: '0};
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sample = m_axis_tdata;
                got.ovf = m_axis_tuser;
                if (got.ovf)
                begin
                    overflow_seen++;
                end
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result sample_out=%0d overflow=%0b",
                             $time, got.sample, got.ovf);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.sample !== want.sample)
                    begin
                        fail_count++;
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, want.sample, got.sample);
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        fail_count++;
                        $display("%0t: overflow mismatch, expected %0b, actual %0b",
                                 $time, want.ovf, got.ovf);
                    end
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

// File: verif/tb_biquad_cascade_df1_filter.sv
// ----------------------------------------------------------------------------
// Biquad cascade regression bench
// Drives directed and random sample, coefficient, clear and unused requests
// through the filter under four idling patterns and many section counts;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_biquad_cascade_df1_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import bcdf_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = 400;
    localparam longint     CYCLE_LIMIT = 3_000_000;
    localparam logic signed [31:0] COEF_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = MODE_FILTER;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    int     fail_count;
    int     outstanding;
    int     overflow_seen;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     samples_sent = 0;
    int     coefs_sent = 0;
    int     clears_sent = 0;
    longint cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    biquad_cascade_df1_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    biquad_cascade_df1_filter_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .overflow_seen (overflow_seen)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, outstanding);
            $display("biquad_cascade_df1_filter regression: fail");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One request: optional idle cycles, then hold it until accepted.
    task automatic send_request(input logic [1:0] mode, input logic [15:0] sample,
                                input logic [2:0] stage, input logic [2:0] slot,
                                input logic [31:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        // sample_in[15:0], coef_stage[18:16], coef_slot[21:19], coef_value[53:22]
        s_axis_tdata <= {2'b00, value, slot, stage, sample};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        case (mode)
            MODE_FILTER: samples_sent++;
            MODE_COEF:   coefs_sent++;
            MODE_CLEAR:  clears_sent++;
            default:     ;
        endcase
    endtask

    task automatic filter_sample(input logic [15:0] sample);
        send_request(MODE_FILTER, sample, 3'($urandom), 3'($urandom), $urandom);
    endtask

    task automatic write_coef(input logic [2:0] stage, input logic [2:0] slot,
                              input logic [31:0] value);
        send_request(MODE_COEF, 16'($urandom), stage, slot, value);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_sections(input logic [3:0] count);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= count;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random if wild; else mild: bounded feed-forward, roughly stable recursion.
    task automatic load_section(input logic [2:0] stage, input bit wild);
        logic signed [31:0] a0;
        if (wild)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                write_coef(stage, 3'(k), $urandom);
            end
        end
        else
        begin
            case ($urandom_range(9))
                0:       a0 = '0;
                1:       a0 = -COEF_ONE;
                2:       a0 = $urandom_range(1, 4096);
                default: a0 = COEF_ONE + $signed(32'($urandom_range(0, 1 << 26)));
            endcase
            write_coef(stage, SLOT_B0, $signed(32'($urandom_range(0, 1 << 28))) - (1 <<< 27));
            write_coef(stage, SLOT_B1, $signed(32'($urandom_range(0, 1 << 28))) - (1 <<< 27));
            write_coef(stage, SLOT_B2, $signed(32'($urandom_range(0, 1 << 28))) - (1 <<< 27));
            write_coef(stage, SLOT_A0, a0);
            write_coef(stage, SLOT_A1, $signed(32'($urandom_range(0, 3 << 28))) - (3 <<< 27));
            write_coef(stage, SLOT_A2, $signed(32'($urandom_range(0, 1 << 28))) - (1 <<< 27));
        end
    endtask

    initial
    begin
        logic [3:0] count;
        int         roll;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity sections, sample extremes, zero and negative a0,
        // coefficient extremes, ignored slots, unused mode, clear, saturation.
        filter_sample(16'h7fff);
        filter_sample(16'h8000);
        filter_sample(16'h0000);
        write_coef(3'd0, SLOT_A0, '0);
        filter_sample(16'h0001);
        filter_sample(16'hffff);
        send_request(MODE_CLEAR, '0, '0, '0, '0);
        filter_sample(16'h0000);
        write_coef(3'd0, SLOT_A0, -COEF_ONE);
        filter_sample(16'h1234);
        filter_sample(16'h8000);
        write_coef(3'd0, SLOT_A0, COEF_ONE);
        write_coef(3'd0, SLOT_B0, COEF_MAX);
        filter_sample(16'h7fff);
        write_coef(3'd0, SLOT_B1, COEF_MIN);
        write_coef(3'd0, 3'd6, '0);
        write_coef(3'd7, 3'd7, '0);
        send_request(MODE_UNUSED, 16'h7fff, '1, '1, '1);
        filter_sample(16'h8000);
        filter_sample(16'h4000);
        send_request(MODE_CLEAR, '1, '1, '1, '1);
        write_coef(3'd0, SLOT_B0, COEF_ONE);
        write_coef(3'd0, SLOT_B1, '0);
        filter_sample(16'hc000);
        set_sections(4'd0);
        filter_sample(16'h0100);
        set_sections(4'd15);
        filter_sample(16'hff00);

        // Random: four idling phases, four section settings each.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                case (seg)
                    0:       count = (phase % 2) ? 4'd8 : 4'd1;
                    1:       count = (phase % 2) ? 4'd0 : 4'd15;
                    default: count = 4'($urandom_range(1, 4));
                endcase
                set_sections(count);
                for (int s = 0; s < MAX_STAGES_DEF; s++)
                begin
                    load_section(3'(s), $urandom_range(7) == 0);
                end
                for (int k = 0; k < 70; k++)
                begin
                    roll = $urandom_range(99);
                    if (k == 35 && seg == 2)
                    begin
                        drain();
                    end
                    if (roll < 82)
                    begin
                        filter_sample(16'($urandom));
                    end
                    else if (roll < 88)
                    begin
                        write_coef(3'($urandom), 3'($urandom), $urandom);
                    end
                    else if (roll < 93)
                    begin
                        send_request(MODE_CLEAR, 16'($urandom), 3'($urandom), 3'($urandom),
                                     $urandom);
                    end
                    else
                    begin
                        send_request(MODE_UNUSED, 16'($urandom), 3'($urandom), 3'($urandom),
                                     $urandom);
                    end
                end
            end
        end

        drain();
        $display("Covered %0d samples, %0d coefficient writes and %0d clears;",
                 samples_sent, coefs_sent, clears_sent);
        $display("section counts 0 to 15, four idling patterns, %0d overflow results.",
                 overflow_seen);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("biquad_cascade_df1_filter regression: pass");
        end
        else
        begin
            $display("%0t: %0d mismatches, %0d results never arrived",
                     $time, fail_count, outstanding);
            $display("biquad_cascade_df1_filter regression: fail");
        end
        $finish;
    end

endmodule
